>>> rtl/core/spd_pkg.sv
// shared types, constants and the crc byte function for the sensor packet deframer
// no dependencies
package spd_pkg;

    localparam int HEADER_BYTES = 24;
    localparam int FIFO_DEPTH   = 4;
    localparam int POS_W        = 17;

    localparam logic [POS_W-1:0] POS_SAT      = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_HDR_END  = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_CRC_LAST = POS_W'(HEADER_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MIN_LEN  = POS_W'(HEADER_BYTES + 2);
    localparam logic [POS_W-1:0] POS_FIELDS   = POS_W'(16);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_BAD_HDR   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam logic [2:0] PH_TYPE  = 3'd0;
    localparam logic [2:0] PH_ID    = 3'd1;
    localparam logic [2:0] PH_SIZE1 = 3'd2;
    localparam logic [2:0] PH_SIZE0 = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_STAMP = 3'd5;
    localparam logic [2:0] PH_QUAL  = 3'd6;

    localparam logic [1:0] REG_MAGIC   = 2'd0;
    localparam logic [1:0] REG_VERSION = 2'd1;
    localparam logic [1:0] REG_CRC_ON  = 2'd2;

    localparam int TDATA_W = 112;

    typedef struct packed {
        logic        length_mismatch;
        logic        sequence_error;
        logic        crc_error;
        logic [1:0]  status_code;
        logic [7:0]  quality;
        logic [15:0] length;
        logic [7:0]  dev_id;
        logic [7:0]  dev_type;
        logic [63:0] value;
        logic [1:0]  kind;
        logic        last;
    } result_t;

    typedef struct packed {
        result_t res0;
        result_t res1;
        logic    two;
    } record_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/spd_front.sv
// front part: byte parser, crc, header checks, entry walk and result building
// depends on spd_pkg
module spd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_take,
    input  logic [7:0]           byte_value,
    input  logic                 final_byte,
    input  logic                 cfg_take,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 rec_push,
    output spd_pkg::record_t     rec_data
);

    logic [31:0] magic_reg;
    logic [15:0] version_reg;
    logic        crc_on_reg;

    logic [16:0] pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [63:0] hdr0_reg, hdr0_next;
    logic [63:0] hdr1_reg, hdr1_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] ecount_reg, ecount_next;
    logic [31:0] ef0_reg, ef0_next;
    logic [63:0] ef1_reg, ef1_next;
    logic [15:0] done_reg, done_next;
    logic [16:0] consumed_reg, consumed_next;
    logic [31:0] expseq_reg, expseq_next;
    logic        bad_reg, bad_next;
    logic        seqerr_reg, seqerr_next;

    logic [16:0] cons_amt;
    logic [17:0] cons_sum;
    logic [15:0] dsz;
    logic [15:0] hdr_count;
    logic [15:0] dsz_new;
    spd_pkg::result_t ent_res, stat_res;
    logic        ent_out;

    assign dsz       = ef0_reg[15:0];
    assign hdr_count = hdr1_reg[47:32];
    assign dsz_new   = {ef0_reg[15:8], byte_value};

    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        hdr0_next   = hdr0_reg;
        hdr1_next   = hdr1_reg;
        rcrc_next   = rcrc_reg;
        phase_next  = phase_reg;
        ecount_next = ecount_reg;
        ef0_next    = ef0_reg;
        ef1_next    = ef1_reg;
        done_next   = done_reg;
        expseq_next = expseq_reg;
        bad_next    = bad_reg;
        seqerr_next = seqerr_reg;
        cons_amt    = '0;
        ent_out     = 1'b0;
        ent_res     = '0;
        stat_res    = '0;

        if (pos_reg < spd_pkg::POS_HDR_END) begin
            crc_next = spd_pkg::crc_byte(crc_reg, byte_value);
            if (pos_reg < spd_pkg::POS_FIELDS) begin
                if (!pos_reg[3]) begin
                    hdr0_next = {hdr0_reg[55:0], byte_value};
                end else begin
                    hdr1_next = {hdr1_reg[55:0], byte_value};
                end
            end
        end else if (pos_reg < spd_pkg::POS_MIN_LEN) begin
            rcrc_next = {rcrc_reg[7:0], byte_value};
            if (pos_reg == spd_pkg::POS_CRC_LAST) begin
                bad_next = (hdr0_reg[63:32] != magic_reg) || (hdr0_reg[31:16] != version_reg);
                if (!bad_next) begin
                    if (expseq_reg == 32'd0) begin
                        expseq_next = hdr1_reg[31:0] + 32'd1;
                        seqerr_next = 1'b0;
                    end else if (hdr1_reg[31:0] == expseq_reg) begin
                        expseq_next = expseq_reg + 32'd1;
                        seqerr_next = 1'b0;
                    end else begin
                        seqerr_next = 1'b1;
                    end
                end
            end
        end else if (!bad_reg && (done_reg < hdr_count)) begin
            unique case (phase_reg)
                spd_pkg::PH_ID: begin
                    ef0_next   = ef0_reg | {8'h00, byte_value, 16'h0000};
                    cons_amt   = 17'd1;
                    phase_next = spd_pkg::PH_SIZE1;
                end
                spd_pkg::PH_SIZE1: begin
                    ef0_next   = ef0_reg | {16'h0000, byte_value, 8'h00};
                    phase_next = spd_pkg::PH_SIZE0;
                end
                spd_pkg::PH_SIZE0: begin
                    ef0_next    = ef0_reg | {24'h000000, byte_value};
                    cons_amt    = 17'd2;
                    ecount_next = '0;
                    ef1_next    = '0;
                    phase_next  = (dsz_new != 16'h0000) ? spd_pkg::PH_DATA : spd_pkg::PH_STAMP;
                end
                spd_pkg::PH_DATA: begin
                    ent_out           = 1'b1;
                    ent_res.kind      = spd_pkg::KIND_DATA;
                    ent_res.value     = {56'h0, byte_value};
                    ecount_next       = ecount_reg + 16'd1;
                    if (ecount_next == dsz) begin
                        cons_amt    = {1'b0, dsz};
                        ecount_next = '0;
                        phase_next  = spd_pkg::PH_STAMP;
                    end
                end
                spd_pkg::PH_STAMP: begin
                    ef1_next    = ef1_reg | ({56'h0, byte_value} << {ecount_reg[2:0], 3'b000});
                    ecount_next = ecount_reg + 16'd1;
                    if (ecount_next >= 16'd8) begin
                        cons_amt    = 17'd8;
                        ecount_next = '0;
                        phase_next  = spd_pkg::PH_QUAL;
                    end
                end
                spd_pkg::PH_QUAL: begin
                    cons_amt            = 17'd1;
                    ent_out             = 1'b1;
                    ent_res.kind        = spd_pkg::KIND_ENTRY;
                    ent_res.value       = ef1_reg;
                    ent_res.dev_type    = ef0_reg[31:24];
                    ent_res.dev_id      = ef0_reg[23:16];
                    ent_res.length      = dsz;
                    ent_res.quality     = byte_value;
                    done_next           = done_reg + 16'd1;
                    phase_next          = spd_pkg::PH_TYPE;
                    ecount_next         = '0;
                    ef0_next            = '0;
                    ef1_next            = '0;
                end
                default: begin
                    ef0_next   = {byte_value, 24'h000000};
                    ef1_next   = '0;
                    cons_amt   = 17'd1;
                    phase_next = spd_pkg::PH_ID;
                end
            endcase
        end

        cons_sum      = {1'b0, consumed_reg} + {1'b0, cons_amt};
        consumed_next = cons_sum[17] ? spd_pkg::POS_SAT : cons_sum[16:0];
        pos_next      = (pos_reg == spd_pkg::POS_SAT) ? pos_reg : pos_reg + 17'd1;

        stat_res.kind = spd_pkg::KIND_STATUS;
        stat_res.last = 1'b1;
        if (pos_next < spd_pkg::POS_MIN_LEN) begin
            stat_res.status_code = spd_pkg::ST_SHORT;
        end else begin
            stat_res.value       = {32'h0, hdr1_reg[31:0]};
            stat_res.dev_type    = hdr0_reg[15:8];
            stat_res.dev_id      = hdr0_reg[7:0];
            stat_res.length      = hdr_count;
            stat_res.crc_error   = crc_on_reg && (crc_next != rcrc_next);
            if (bad_next) begin
                stat_res.status_code = spd_pkg::ST_BAD_HDR;
            end else begin
                stat_res.status_code = (done_next < hdr_count) ?
                                       spd_pkg::ST_TRUNCATED : spd_pkg::ST_VALID;
                stat_res.sequence_error  = seqerr_next;
                stat_res.length_mismatch = consumed_next != {1'b0, hdr1_reg[63:48]};
            end
        end

        ent_res.last = !final_byte;

        if (final_byte) begin
            pos_next      = '0;
            crc_next      = spd_pkg::CRC_INIT;
            hdr0_next     = '0;
            hdr1_next     = '0;
            rcrc_next     = '0;
            phase_next    = spd_pkg::PH_TYPE;
            ecount_next   = '0;
            ef0_next      = '0;
            ef1_next      = '0;
            done_next     = '0;
            consumed_next = '0;
            bad_next      = 1'b0;
            seqerr_next   = 1'b0;
        end
    end

    always_comb begin
        rec_push = byte_take && (ent_out || final_byte);
        rec_data = '0;
        if (ent_out) begin
            rec_data.res0 = ent_res;
            rec_data.res1 = stat_res;
            rec_data.two  = final_byte;
        end else begin
            rec_data.res0 = stat_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg    <= '0;
            version_reg  <= '0;
            crc_on_reg   <= 1'b1;
            pos_reg      <= '0;
            crc_reg      <= spd_pkg::CRC_INIT;
            hdr0_reg     <= '0;
            hdr1_reg     <= '0;
            rcrc_reg     <= '0;
            phase_reg    <= spd_pkg::PH_TYPE;
            ecount_reg   <= '0;
            ef0_reg      <= '0;
            ef1_reg      <= '0;
            done_reg     <= '0;
            consumed_reg <= '0;
            expseq_reg   <= 32'd1;
            bad_reg      <= 1'b0;
            seqerr_reg   <= 1'b0;
        end else begin
            if (cfg_take) begin
                unique case (cfg_index)
                    spd_pkg::REG_MAGIC:   magic_reg   <= cfg_data;
                    spd_pkg::REG_VERSION: version_reg <= cfg_data[15:0];
                    spd_pkg::REG_CRC_ON:  crc_on_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (byte_take) begin
                pos_reg      <= pos_next;
                crc_reg      <= crc_next;
                hdr0_reg     <= hdr0_next;
                hdr1_reg     <= hdr1_next;
                rcrc_reg     <= rcrc_next;
                phase_reg    <= phase_next;
                ecount_reg   <= ecount_next;
                ef0_reg      <= ef0_next;
                ef1_reg      <= ef1_next;
                done_reg     <= done_next;
                consumed_reg <= consumed_next;
                expseq_reg   <= expseq_next;
                bad_reg      <= bad_next;
                seqerr_reg   <= seqerr_next;
            end
        end
    end

endmodule

>>> rtl/core/spd_fifo.sv
// short record queue between parser and output stage
// depends on spd_pkg
module spd_fifo #(
    parameter int DEPTH = spd_pkg::FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  spd_pkg::record_t push_data,
    output logic             full,
    input  logic             pop,
    output spd_pkg::record_t pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    spd_pkg::record_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = count_reg == FULL_CNT;
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

>>> rtl/core/spd_back.sv
// back part: output register that plays one or two results of each record
// depends on spd_pkg
module spd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        empty,
    input  spd_pkg::record_t            pop_data,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [spd_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    spd_pkg::record_t rec_reg;
    logic             sel_reg;
    logic             vld_reg;
    spd_pkg::result_t cur;
    logic             finishing;
    logic             load;

    assign cur       = sel_reg ? rec_reg.res1 : rec_reg.res0;
    assign finishing = vld_reg && m_tready && (sel_reg || !rec_reg.two);
    assign load      = !vld_reg || finishing;
    assign pop       = load && !empty;

    assign m_tvalid = vld_reg;
    assign m_tuser  = cur.kind;
    assign m_tlast  = cur.last;
    assign m_tdata  = {3'b000, cur.length_mismatch, cur.sequence_error, cur.crc_error,
                       cur.status_code, cur.quality, cur.length, cur.dev_id,
                       cur.dev_type, cur.value};

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= pop_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            sel_reg <= 1'b0;
        end else if (load) begin
            vld_reg <= !empty;
            sel_reg <= 1'b0;
        end else if (vld_reg && m_tready) begin
            sel_reg <= 1'b1;
        end
    end

endmodule

>>> rtl/core/sensor_packet_deframer.sv
// top level of the sensor packet deframer: parser, record queue and output stage
// depends on spd_pkg, spd_front, spd_fifo, spd_back
//
// Takes one packet byte per cycle while s_tready is high, with no gaps needed: the parser updates
// the header crc, the header checks and the entry walk in the cycle a byte is accepted and queues
// one record per byte that yields results. A record usually carries one result; a final byte
// that also yields a data byte or an entry result carries two, which the output stage plays one
// after the other. s_tready drops only when the record queue (FIFO_DEPTH records) is full, so
// sustained rate is one byte per clock as long as m_tready stays high and no such final byte
// holds the output for its second result. Configuration writes are taken at any time (cfg_ready
// is always high) and are meant for idle periods between packets.
module sensor_packet_deframer #(
    parameter int FIFO_DEPTH = spd_pkg::FIFO_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // byte_value
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // value, entry type, entry id, length, quality, status_code, crc_error,
    // sequence_error, length_mismatch, zero pad
    output logic [spd_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,   // kind
    output logic                        m_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [31:0]                 cfg_data
);

    logic             full, empty, pop, rec_push;
    spd_pkg::record_t rec_data, pop_data;

    assign s_tready  = !full;
    assign cfg_ready = 1'b1;

    spd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_take  (s_tvalid && s_tready),
        .byte_value (s_tdata),
        .final_byte (s_tlast),
        .cfg_take   (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rec_push   (rec_push),
        .rec_data   (rec_data)
    );

    spd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (rec_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    spd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/core/spd_checker.sv
// port level checks of the sensor packet deframer, bound to the top level
// depends on spd_pkg and sensor_packet_deframer
module spd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [spd_pkg::TDATA_W-1:0] m_tdata,
    input logic [1:0]                  m_tuser,
    input logic                        m_tlast
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == spd_pkg::KIND_DATA || m_tuser == spd_pkg::KIND_ENTRY ||
                      m_tuser == spd_pkg::KIND_STATUS))
        else $error("unknown result kind");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == spd_pkg::KIND_STATUS |-> m_tlast)
        else $error("packet status not marked last");

    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == spd_pkg::KIND_DATA |-> m_tdata[spd_pkg::TDATA_W-1:8] == '0)
        else $error("data byte result carries stray bits");

endmodule

bind sensor_packet_deframer spd_checker u_spd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
